// ===== rtl/lap_pkg.sv =====
// shared types, constants and codes of the linear actuator positioner
package lap_pkg;

	// averaging window and accumulator widths
	localparam int AVG_COUNT = 100;
	localparam int SUM_W     = 19;
	localparam int CNT_W     = 7;

	// position divider: numerator bits, one quotient bit per step
	localparam int NUM_W     = 35;
	localparam int DSR_W     = 20;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = 6;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-1:0] ADDR_CAL_LOW  = 5'd0;
	localparam logic [ADDR_W-1:0] ADDR_CAL_HIGH = 5'd4;
	localparam logic [ADDR_W-1:0] ADDR_STROKE   = 5'd8;
	localparam logic [ADDR_W-1:0] ADDR_DEADBAND = 5'd12;
	localparam logic [ADDR_W-1:0] ADDR_OVERSHOOT = 5'd16;

	// register reset values
	localparam logic [11:0] RST_CAL_LOW   = 12'd346;
	localparam logic [11:0] RST_CAL_HIGH  = 12'd1145;
	localparam logic [7:0]  RST_STROKE    = 8'd60;
	localparam logic [9:0]  RST_DEADBAND  = 10'd32;
	localparam logic [9:0]  RST_OVERSHOOT = 10'd51;

	// item function codes
	localparam logic [1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [1:0] FUNC_ABS    = 2'd1;
	localparam logic [1:0] FUNC_REL    = 2'd2;

	typedef enum logic [1:0] {
		DRV_STOP = 2'd0,
		DRV_FWD  = 2'd1,
		DRV_BWD  = 2'd2
	} drive_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_FWD  = 3'd1,
		PH_FSET = 3'd2,
		PH_FREV = 3'd3,
		PH_BWD  = 3'd4,
		PH_BSET = 3'd5,
		PH_BFWD = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_PREP,
		C_SCALE,
		C_DIV,
		C_APPLY
	} ctrl_state_t;

	typedef struct packed {
		logic [11:0] cal_low;
		logic [11:0] cal_high;
		logic [7:0]  stroke_mm;
		logic [9:0]  deadband;
		logic [9:0]  overshoot_limit;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic prep;
		logic scale;
		logic div_step;
		logic apply;
	} dp_cmd_t;

	typedef struct packed {
		logic win_end;
	} dp_status_t;

endpackage

// ===== rtl/linear_actuator_positioner_unit.sv =====
// top level: configuration registers, controller and datapath of the actuator positioner
//
// Input channel (in_valid/in_ready) carries one item: func 0 is an ADC sample, func 1 an
// absolute move, func 2 a relative move; func 3 only reports the present state. Every item
// gives exactly one result on the output channel (out_valid/out_ready): motor drive,
// last window position in signed 1/64 mm, busy and done flags.
// Items that do not close an averaging window are answered from the output register on
// the cycle after acceptance, so such items flow at one per cycle while results are taken.
// The sample that closes a window of AVG_COUNT samples starts the position calculation:
// the set-up states C_PREP and C_SCALE, the restoring divider in C_DIV (one quotient
// bit per cycle) and C_APPLY, which judges the move once the output register is free;
// no item is taken meanwhile. The user must write configuration through the APB port
// (registers at byte addresses 0..16) only while the block is idle; the block itself
// does not enforce this. pready is always high and reads return the register value.
// Reset (arst_n low) loads the calibration defaults, clears the window accumulator,
// position and goal, and leaves the motor stopped; no clearing pass is needed.
// A stalled receiver holds the result in the output register; a new item is accepted
// only in a cycle where that register is empty or being emptied.
module linear_actuator_positioner_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lap_pkg::ADDR_W-1:0]  paddr,
	input  logic [lap_pkg::DATA_W-1:0]  pwdata,
	output logic [lap_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  func,
	input  logic [11:0]                 sample,
	input  logic signed [14:0]          target_pos,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  drive,
	output logic signed [14:0]          position,
	output logic                        busy_res,
	output logic                        done_res
);

	logic [11:0] cal_low_q;
	logic [11:0] cal_high_q;
	logic [7:0]  stroke_q;
	logic [9:0]  deadband_q;
	logic [9:0]  overshoot_q;
	logic        wr_en;

	lap_pkg::cfg_t       cfg;
	lap_pkg::dp_cmd_t    cmd;
	lap_pkg::dp_status_t status;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_low_q   <= lap_pkg::RST_CAL_LOW;
			cal_high_q  <= lap_pkg::RST_CAL_HIGH;
			stroke_q    <= lap_pkg::RST_STROKE;
			deadband_q  <= lap_pkg::RST_DEADBAND;
			overshoot_q <= lap_pkg::RST_OVERSHOOT;
		end else if (wr_en) begin
			case (paddr)
				lap_pkg::ADDR_CAL_LOW:   cal_low_q   <= pwdata[11:0];
				lap_pkg::ADDR_CAL_HIGH:  cal_high_q  <= pwdata[11:0];
				lap_pkg::ADDR_STROKE:    stroke_q    <= pwdata[7:0];
				lap_pkg::ADDR_DEADBAND:  deadband_q  <= pwdata[9:0];
				lap_pkg::ADDR_OVERSHOOT: overshoot_q <= pwdata[9:0];
				default: begin
					cal_low_q <= cal_low_q;
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr)
			lap_pkg::ADDR_CAL_LOW:   prdata = lap_pkg::DATA_W'(cal_low_q);
			lap_pkg::ADDR_CAL_HIGH:  prdata = lap_pkg::DATA_W'(cal_high_q);
			lap_pkg::ADDR_STROKE:    prdata = lap_pkg::DATA_W'(stroke_q);
			lap_pkg::ADDR_DEADBAND:  prdata = lap_pkg::DATA_W'(deadband_q);
			lap_pkg::ADDR_OVERSHOOT: prdata = lap_pkg::DATA_W'(overshoot_q);
			default:                 prdata = '0;
		endcase
	end

	assign cfg.cal_low         = cal_low_q;
	assign cfg.cal_high        = cal_high_q;
	assign cfg.stroke_mm       = stroke_q;
	assign cfg.deadband        = deadband_q;
	assign cfg.overshoot_limit = overshoot_q;

	lap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lap_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.func       (func),
		.sample     (sample),
		.target_pos (target_pos),
		.status     (status),
		.drive      (drive),
		.position   (position),
		.busy_res   (busy_res),
		.done_res   (done_res)
	);

	// an idle actuator is never driven
	a_idle_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (busy_res || drive == lap_pkg::DRV_STOP))
		else $error("motor driven while no move is in progress");

	// a finished move leaves the block idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> !busy_res)
		else $error("move reported done while still busy");

	// no item is taken while a result would be overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input accepted with a stalled result pending");

	// a calibration write lands in its register
	a_cal_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && paddr == lap_pkg::ADDR_CAL_LOW) |=> (cal_low_q == $past(pwdata[11:0])))
		else $error("cal_low write lost");

endmodule

// ===== rtl/lap_ctrl.sv =====
// controller: item handshake, window-end sequencing and output register valid
module lap_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  lap_pkg::dp_status_t status,
	output lap_pkg::dp_cmd_t    cmd
);

	lap_pkg::ctrl_state_t state_q, state_d;
	logic [lap_pkg::DIV_CNT_W-1:0] step_q;
	logic out_valid_q;
	logic out_free;
	logic out_load;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_free = !out_valid_q || out_ready;
		case (state_q)
			lap_pkg::C_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					cmd.accept = 1'b1;
					if (status.win_end) begin
						state_d = lap_pkg::C_PREP;
					end
				end
			end
			lap_pkg::C_PREP: begin
				cmd.prep = 1'b1;
				state_d  = lap_pkg::C_SCALE;
			end
			lap_pkg::C_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = lap_pkg::C_DIV;
			end
			lap_pkg::C_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == lap_pkg::DIV_CNT_W'(lap_pkg::DIV_STEPS - 1)) begin
					state_d = lap_pkg::C_APPLY;
				end
			end
			lap_pkg::C_APPLY: begin
				if (out_free) begin
					cmd.apply = 1'b1;
					state_d   = lap_pkg::C_IDLE;
				end
			end
			default: begin
				state_d = lap_pkg::C_IDLE;
			end
		endcase
		out_load = (cmd.accept && !status.win_end) || cmd.apply;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lap_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == lap_pkg::C_DIV) begin
			step_q <= step_q + 1'b1;
		end else begin
			step_q <= '0;
		end
	end

	// output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/lap_dp.sv =====
// datapath: sample averaging, position divider, move sequencing and output register
module lap_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  lap_pkg::dp_cmd_t    cmd,
	input  lap_pkg::cfg_t       cfg,
	input  logic [1:0]          func,
	input  logic [11:0]         sample,
	input  logic signed [14:0]  target_pos,
	output lap_pkg::dp_status_t status,
	output logic [1:0]          drive,
	output logic signed [14:0]  position,
	output logic                busy_res,
	output logic                done_res
);

	// move and averaging state
	logic [lap_pkg::SUM_W-1:0] sum_q;
	logic [lap_pkg::CNT_W-1:0] cnt_q;
	logic signed [14:0]        cur_q;
	logic signed [14:0]        goal_q;
	lap_pkg::phase_t           phase_q;
	logic [1:0]                pass_q;
	lap_pkg::drive_t           drv_q;

	// window result pipeline
	logic [lap_pkg::SUM_W-1:0]  win_sum_q;
	logic signed [20:0]         diff_s1;
	logic signed [19:0]         den_s1;
	logic                       zero_s1;
	logic [lap_pkg::NUM_W-1:0]  num_q;
	logic [lap_pkg::DSR_W-1:0]  dsr_q;
	logic [lap_pkg::DSR_W-1:0]  rem_q;
	logic                       neg_q;
	logic                       zero_q;

	// output register
	lap_pkg::drive_t    drive_q;
	logic signed [14:0] position_q;
	logic               busy_q;
	logic               done_q;

	logic [lap_pkg::SUM_W-1:0] sum_inc;
	logic [lap_pkg::CNT_W-1:0] cnt_inc;

	function automatic logic signed [14:0] sat15(input logic signed [15:0] v);
		logic signed [14:0] r;
		if (v > 16'sd16383) begin
			r = 15'sd16383;
		end else if (v < -16'sd16384) begin
			r = -15'sd16384;
		end else begin
			r = v[14:0];
		end
		return r;
	endfunction

	// accumulation and window end detection
	always_comb begin
		sum_inc        = sum_q + lap_pkg::SUM_W'(sample);
		cnt_inc        = cnt_q + 1'b1;
		status.win_end = (func == lap_pkg::FUNC_SAMPLE) &&
			(cnt_inc >= lap_pkg::CNT_W'(lap_pkg::AVG_COUNT));
	end

	// move command decode
	logic signed [15:0] err;
	logic signed [15:0] db_s;
	logic signed [15:0] rel_sum;
	lap_pkg::phase_t    mv_phase;
	logic [1:0]         mv_pass;
	lap_pkg::drive_t    mv_drv;
	logic signed [14:0] mv_goal;
	logic               mv_done;

	always_comb begin
		err      = {target_pos[14], target_pos} - {cur_q[14], cur_q};
		db_s     = $signed({6'b0, cfg.deadband});
		rel_sum  = {cur_q[14], cur_q} + {target_pos[14], target_pos};
		mv_phase = phase_q;
		mv_pass  = pass_q;
		mv_drv   = drv_q;
		mv_goal  = goal_q;
		mv_done  = 1'b0;
		if (phase_q == lap_pkg::PH_IDLE) begin
			case (func)
				lap_pkg::FUNC_ABS: begin
					mv_goal = target_pos;
					if (err >= db_s) begin
						mv_phase = lap_pkg::PH_FWD;
						mv_pass  = 2'd1;
						mv_drv   = lap_pkg::DRV_FWD;
					end else if (err <= -db_s) begin
						mv_phase = lap_pkg::PH_BWD;
						mv_pass  = 2'd1;
						mv_drv   = lap_pkg::DRV_BWD;
					end else begin
						mv_phase = lap_pkg::PH_IDLE;
						mv_pass  = 2'd0;
						mv_drv   = lap_pkg::DRV_STOP;
						mv_done  = 1'b1;
					end
				end
				lap_pkg::FUNC_REL: begin
					mv_goal = sat15(rel_sum);
					mv_pass = 2'd3;
					if (target_pos > 15'sd0) begin
						mv_phase = lap_pkg::PH_FWD;
						mv_drv   = lap_pkg::DRV_FWD;
					end else begin
						mv_phase = lap_pkg::PH_BWD;
						mv_drv   = lap_pkg::DRV_BWD;
					end
				end
				default: begin
					mv_done = 1'b0;
				end
			endcase
		end
	end

	// window offset and calibration span
	logic [lap_pkg::SUM_W-1:0] low_scaled;
	logic signed [12:0]        span;
	logic signed [19:0]        den;
	logic signed [20:0]        diff;

	always_comb begin
		low_scaled = lap_pkg::SUM_W'({7'b0, cfg.cal_low} *
			lap_pkg::SUM_W'(lap_pkg::AVG_COUNT));
		span = $signed({1'b0, cfg.cal_high}) - $signed({1'b0, cfg.cal_low});
		den  = 20'({{7{span[12]}}, span}) * 20'(lap_pkg::AVG_COUNT);
		diff = $signed({2'b0, win_sum_q}) - $signed({2'b0, low_scaled});
	end

	// scale by stroke, fold signs and form rounding numerator
	logic signed [29:0]        prod;
	logic                      prod_neg;
	logic                      div_neg;
	logic [26:0]               mag;
	logic signed [19:0]        den_abs;
	logic [lap_pkg::NUM_W-1:0] num_init;

	always_comb begin
		prod     = $signed({{9{diff_s1[20]}}, diff_s1}) * $signed({22'b0, cfg.stroke_mm});
		prod_neg = prod[29];
		div_neg  = den_s1[19] ? (!prod_neg && (prod != 30'sd0)) : prod_neg;
		mag      = prod_neg ? 27'(-prod) : 27'(prod);
		den_abs  = den_s1[19] ? -den_s1 : den_s1;
		num_init = lap_pkg::NUM_W'({mag, 7'b0}) + lap_pkg::NUM_W'(den_abs[18:0]);
	end

	// one restoring division step
	logic [lap_pkg::DSR_W:0]   trial;
	logic                      trial_ge;
	logic [lap_pkg::DSR_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, num_q[lap_pkg::NUM_W-1]};
		trial_ge = trial >= {1'b0, dsr_q};
		rem_next = trial_ge ? lap_pkg::DSR_W'(trial - {1'b0, dsr_q})
			: lap_pkg::DSR_W'(trial);
	end

	// rounded, signed and saturated window position
	logic signed [14:0] pos_new;

	always_comb begin
		if (zero_q) begin
			pos_new = 15'sd0;
		end else if (neg_q) begin
			pos_new = (num_q > lap_pkg::NUM_W'(16384)) ? -15'sd16384 : -$signed(num_q[14:0]);
		end else begin
			pos_new = (num_q > lap_pkg::NUM_W'(16383)) ? 15'sd16383 : $signed(num_q[14:0]);
		end
	end

	// judge the move once per window
	logic signed [16:0] p17;
	logic signed [16:0] g17;
	logic signed [16:0] g_over;
	logic signed [16:0] g_db;
	lap_pkg::phase_t    adv_phase;
	logic [1:0]         adv_pass;
	lap_pkg::drive_t    adv_drv;
	logic               adv_done;
	logic               adv_finish;

	always_comb begin
		p17        = {{2{pos_new[14]}}, pos_new};
		g17        = {{2{goal_q[14]}}, goal_q};
		g_over     = g17 + $signed({7'b0, cfg.overshoot_limit});
		g_db       = g17 + $signed({7'b0, cfg.deadband});
		adv_phase  = phase_q;
		adv_pass   = pass_q;
		adv_drv    = drv_q;
		adv_finish = 1'b0;
		case (phase_q)
			lap_pkg::PH_IDLE: begin
				adv_finish = 1'b0;
			end
			lap_pkg::PH_FWD: begin
				if (p17 >= g17) begin
					if (pass_q == 2'd3) begin
						adv_finish = 1'b1;
					end else begin
						adv_phase = lap_pkg::PH_FSET;
						adv_drv   = lap_pkg::DRV_STOP;
					end
				end
			end
			lap_pkg::PH_FSET: begin
				if (p17 < g17) begin
					adv_phase = lap_pkg::PH_FWD;
					adv_pass  = pass_q + 2'd1;
					adv_drv   = lap_pkg::DRV_FWD;
				end else if (pass_q == 2'd1 && p17 > g_over) begin
					adv_phase = lap_pkg::PH_FREV;
					adv_drv   = lap_pkg::DRV_BWD;
				end else begin
					adv_finish = 1'b1;
				end
			end
			lap_pkg::PH_FREV: begin
				adv_finish = (p17 <= g17);
			end
			lap_pkg::PH_BWD: begin
				if (p17 <= g17) begin
					if (pass_q == 2'd3) begin
						adv_finish = 1'b1;
					end else begin
						adv_phase = lap_pkg::PH_BSET;
						adv_drv   = lap_pkg::DRV_STOP;
					end
				end
			end
			lap_pkg::PH_BSET: begin
				if (p17 > g17) begin
					adv_phase = lap_pkg::PH_BWD;
					adv_pass  = pass_q + 2'd1;
					adv_drv   = lap_pkg::DRV_BWD;
				end else if ((pass_q == 2'd1) ? (p17 < g17) : (p17 < g_db)) begin
					adv_phase = lap_pkg::PH_BFWD;
					adv_drv   = lap_pkg::DRV_FWD;
				end else begin
					adv_finish = 1'b1;
				end
			end
			lap_pkg::PH_BFWD: begin
				adv_finish = (p17 >= g17);
			end
			default: begin
				adv_finish = 1'b1;
			end
		endcase
		adv_done = adv_finish;
		if (adv_finish) begin
			adv_phase = lap_pkg::PH_IDLE;
			adv_pass  = 2'd0;
			adv_drv   = lap_pkg::DRV_STOP;
		end
	end

	// averaging and move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			cnt_q   <= '0;
			cur_q   <= '0;
			goal_q  <= '0;
			phase_q <= lap_pkg::PH_IDLE;
			pass_q  <= '0;
			drv_q   <= lap_pkg::DRV_STOP;
		end else if (cmd.accept) begin
			if (func == lap_pkg::FUNC_SAMPLE) begin
				if (status.win_end) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_inc;
					cnt_q <= cnt_inc;
				end
			end
			goal_q  <= mv_goal;
			phase_q <= mv_phase;
			pass_q  <= mv_pass;
			drv_q   <= mv_drv;
		end else if (cmd.apply) begin
			cur_q   <= pos_new;
			phase_q <= adv_phase;
			pass_q  <= adv_pass;
			drv_q   <= adv_drv;
		end
	end

	// divider operands and iteration
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			win_sum_q <= sum_inc;
		end
		if (cmd.prep) begin
			diff_s1 <= diff;
			den_s1  <= den;
			zero_s1 <= (win_sum_q == '0);
		end
		if (cmd.scale) begin
			num_q  <= num_init;
			dsr_q  <= {den_abs[18:0], 1'b0};
			rem_q  <= '0;
			neg_q  <= div_neg;
			zero_q <= zero_s1 || (den_s1 == 20'sd0);
		end else if (cmd.div_step) begin
			num_q <= {num_q[lap_pkg::NUM_W-2:0], trial_ge};
			rem_q <= rem_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.accept && !status.win_end) begin
			drive_q    <= mv_drv;
			position_q <= cur_q;
			busy_q     <= (mv_phase != lap_pkg::PH_IDLE);
			done_q     <= mv_done;
		end else if (cmd.apply) begin
			drive_q    <= adv_drv;
			position_q <= pos_new;
			busy_q     <= (adv_phase != lap_pkg::PH_IDLE);
			done_q     <= adv_done;
		end
	end

	assign drive    = drive_q;
	assign position = position_q;
	assign busy_res = busy_q;
	assign done_res = done_q;

endmodule
